/* sv/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, constants and helper functions of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH         = 4;
   localparam int QUEUE_PTR_BITS      = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] ST_DATA  = 2'd0;
   localparam logic [1:0] ST_CLOSE = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   localparam logic [7:0] CTL_BS = 8'h08;
   localparam logic [7:0] CTL_FF = 8'h0C;
   localparam logic [7:0] CTL_LF = 8'h0A;
   localparam logic [7:0] CTL_CR = 8'h0D;
   localparam logic [7:0] CTL_HT = 8'h09;

   localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
   localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

   typedef struct packed {
      logic [1:0]      last_idx;
      logic [3:0][7:0] bytes;
   } jsu_utf8_type;

   typedef struct packed {
      logic [1:0]      status;
      logic [1:0]      last_idx;
      logic [3:0][7:0] bytes;
      logic [15:0]     length;
   } jsu_group_type;

   typedef struct packed {
      logic          valid;
      jsu_group_type group;
   } jsu_push_type;

   typedef struct packed {
      logic                    full;
      logic                    empty;
      logic [QUEUE_PTR_BITS:0] count;
   } jsu_qstat_type;

   // {valid, digit}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   function automatic jsu_utf8_type utf8_encode(input logic [20:0] cp);
      jsu_utf8_type r;
      r = '0;
      if (cp < 21'h80) begin
         r.bytes[0] = cp[7:0];
         r.last_idx = 2'd0;
      end else if (cp < 21'h800) begin
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
         r.last_idx = 2'd1;
      end else if (cp < 21'h10000) begin
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
         r.last_idx = 2'd2;
      end else begin
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
         r.last_idx = 2'd3;
      end
      return r;
   endfunction

endpackage

/* sv/jsu_front.sv */
// ----------------------------------------------------------------------------
// jsu_front
// Decode FSM: takes one source byte per request and turns it into a group of
// up to four result bytes, an end item, an error item or no item at all.
// ----------------------------------------------------------------------------
module jsu_front #(
   parameter int LENGTH_BITS = jsu_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [7:0]           in_byte,
   input  logic                 final_byte,
   output jsu_pkg::jsu_push_type push,
   output logic                 idle
);
   import jsu_pkg::*;

   localparam int LW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_BODY, MODE_ESC, MODE_HEX, MODE_EXP_BS, MODE_EXP_U, MODE_HEX_LO
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [15:0]            hex_ff, hex_in;
   logic [9:0]             hi_ff, hi_in;
   logic [1:0]             cnt_ff, cnt_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;

   logic                   err, closed, has_data;
   jsu_utf8_type           enc;
   logic [4:0]             hv;
   logic [15:0]            acc_new;
   logic [20:0]            cp;
   logic [LENGTH_BITS:0]   sum;
   logic [LW-1:0]          len_ext;
   logic [15:0]            len_sat;

   assign hv      = hex_value(in_byte);
   assign acc_new = {hex_ff[11:0], hv[3:0]};

   always_comb begin
      err      = 1'b0;
      closed   = 1'b0;
      has_data = 1'b0;
      enc      = '0;
      cp       = '0;
      mode_in  = mode_ff;
      hex_in   = hex_ff;
      hi_in    = hi_ff;
      cnt_in   = cnt_ff;
      case (mode_ff)
         MODE_IDLE: begin
            if (in_byte == CH_QUOTE) mode_in = MODE_BODY;
            else err = 1'b1;
         end
         MODE_BODY: begin
            if (in_byte == CH_QUOTE) closed = 1'b1;
            else if (in_byte == CH_BSLASH) mode_in = MODE_ESC;
            else if (in_byte < CH_SPACE) err = 1'b1;
            else begin
               has_data     = 1'b1;
               enc.bytes[0] = in_byte;
            end
         end
         MODE_ESC: begin
            mode_in  = MODE_BODY;
            has_data = 1'b1;
            case (in_byte)
               CH_QUOTE:  enc.bytes[0] = CH_QUOTE;
               CH_BSLASH: enc.bytes[0] = CH_BSLASH;
               CH_SLASH:  enc.bytes[0] = CH_SLASH;
               CH_B:      enc.bytes[0] = CTL_BS;
               CH_F:      enc.bytes[0] = CTL_FF;
               CH_N:      enc.bytes[0] = CTL_LF;
               CH_R:      enc.bytes[0] = CTL_CR;
               CH_T:      enc.bytes[0] = CTL_HT;
               CH_U: begin
                  has_data = 1'b0;
                  mode_in  = MODE_HEX;
                  hex_in   = '0;
                  cnt_in   = '0;
               end
               default: begin
                  has_data = 1'b0;
                  err      = 1'b1;
               end
            endcase
         end
         MODE_HEX, MODE_HEX_LO: begin
            if (!hv[4]) err = 1'b1;
            else begin
               hex_in = acc_new;
               if (cnt_ff != 2'd3) cnt_in = cnt_ff + 2'd1;
               else begin
                  cnt_in = '0;
                  if (mode_ff == MODE_HEX && acc_new[15:10] == SURR_HIGH_TAG) begin
                     hi_in   = acc_new[9:0];
                     mode_in = MODE_EXP_BS;
                  end else if (mode_ff == MODE_HEX_LO && acc_new[15:10] != SURR_LOW_TAG) begin
                     err = 1'b1;
                  end else begin
                     if (mode_ff == MODE_HEX) cp = {5'd0, acc_new};
                     else cp = 21'h10000 + {1'b0, hi_ff, acc_new[9:0]};
                     enc      = utf8_encode(cp);
                     has_data = 1'b1;
                     mode_in  = MODE_BODY;
                  end
               end
            end
         end
         MODE_EXP_BS: begin
            if (in_byte == CH_BSLASH) mode_in = MODE_EXP_U;
            else err = 1'b1;
         end
         MODE_EXP_U: begin
            if (in_byte == CH_U) begin
               mode_in = MODE_HEX_LO;
               hex_in  = '0;
               cnt_in  = '0;
            end else err = 1'b1;
         end
         default: err = 1'b1;
      endcase
      if (final_byte && !closed) err = 1'b1;
   end

   always_comb begin
      sum = {1'b0, len_ff} + (LENGTH_BITS+1)'({1'b0, enc.last_idx} + 3'd1);
      if (!has_data) len_in = len_ff;
      else if (sum[LENGTH_BITS]) len_in = '1;
      else len_in = sum[LENGTH_BITS-1:0];
      len_ext = LW'(len_ff);
      len_sat = (len_ext > LW'(16'hFFFF)) ? 16'hFFFF : len_ext[15:0];
   end

   always_comb begin
      push                 = '0;
      push.valid           = fire && (err || closed || has_data);
      push.group.bytes     = enc.bytes;
      push.group.last_idx  = enc.last_idx;
      push.group.status    = ST_DATA;
      if (err) begin
         push.group          = '0;
         push.group.status   = ST_ERROR;
      end else if (closed) begin
         push.group          = '0;
         push.group.status   = ST_CLOSE;
         push.group.length   = len_sat;
      end
   end

   assign idle = (mode_ff == MODE_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         hex_ff  <= '0;
         hi_ff   <= '0;
         cnt_ff  <= '0;
         len_ff  <= '0;
      end else if (fire) begin
         if (err || closed) begin
            mode_ff <= MODE_IDLE;
            hex_ff  <= '0;
            hi_ff   <= '0;
            cnt_ff  <= '0;
            len_ff  <= '0;
         end else begin
            mode_ff <= mode_in;
            hex_ff  <= hex_in;
            hi_ff   <= hi_in;
            cnt_ff  <= cnt_in;
            len_ff  <= len_in;
         end
      end
   end

endmodule

/* sv/jsu_queue.sv */
// ----------------------------------------------------------------------------
// jsu_queue
// Small FIFO of decoded groups between the decode FSM and the byte emitter.
// ----------------------------------------------------------------------------
module jsu_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  jsu_pkg::jsu_push_type push,
   input  logic                  pop,
   output jsu_pkg::jsu_group_type head,
   output jsu_pkg::jsu_qstat_type stat
);
   import jsu_pkg::*;

   jsu_group_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      do_push, do_pop;

   assign stat.full  = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign stat.count = count_ff;
   assign head       = entry_ff[rd_ptr_ff];

   assign do_push = push.valid && !stat.full;
   assign do_pop  = pop && !stat.empty;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push.group;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

/* sv/jsu_back.sv */
// ----------------------------------------------------------------------------
// jsu_back
// Byte emitter: walks the head group one result per cycle into the output
// register, while the queue holds a group and the output is not stalled.
// ----------------------------------------------------------------------------
module jsu_back (
   input  logic                   clock,
   input  logic                   reset,
   input  jsu_pkg::jsu_group_type head,
   input  logic                   empty,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_byte,
   output logic [1:0]             rsp_status,
   output logic [15:0]            rsp_length,
   output logic                   rsp_last
);
   import jsu_pkg::*;

   logic        valid_ff;
   logic [1:0]  idx_ff;
   logic [7:0]  byte_ff;
   logic [1:0]  status_ff;
   logic [15:0] length_ff;
   logic        last_ff;
   logic        load, at_last;

   assign load    = !empty && (!valid_ff || rsp_ready);
   assign at_last = (idx_ff == head.last_idx);
   assign pop     = load && at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= at_last ? 2'd0 : idx_ff + 2'd1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= head.bytes[idx_ff];
         status_ff <= head.status;
         length_ff <= head.length;
         last_ff   <= at_last;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_byte   = byte_ff;
   assign rsp_status = status_ff;
   assign rsp_length = length_ff;
   assign rsp_last   = last_ff;

endmodule

/* sv/json_string_unescape_top.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_top
// JSON string unescaper: quoted JSON string bytes in, UTF-8 bytes, an end
// item with the decoded length, or an error item out.
// ----------------------------------------------------------------------------
// channel | dir | tdata                                 | tuser        | tlast
// req     | in  | [7:0] in_byte                         | -            | final_byte
// rsp     | out | [7:0] out_byte, [23:8] decoded_length | [1:0] status | last
//
// Unless stalled, the decode FSM takes one source byte per cycle and the
// emitter sends one result per cycle, so an escape that yields four UTF-8
// bytes holds the emitter until all are sent. A four-group queue lets the two
// sides stall independently; req_tready drops only while that queue is full.
// Reset is synchronous; the block takes requests the cycle after it ends.
// ----------------------------------------------------------------------------
module json_string_unescape_top #(
   parameter int LENGTH_BITS = jsu_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [23:8] decoded_length
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // last
);
   import jsu_pkg::*;

   jsu_push_type  push;
   jsu_group_type head;
   jsu_qstat_type qstat;
   logic          fire, pop, front_idle;
   logic [7:0]    out_byte;
   logic [1:0]    status;
   logic [15:0]   decoded_length;

   assign req_tready = !qstat.full;
   assign fire       = req_tvalid && req_tready;

   jsu_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .in_byte    (req_tdata),
      .final_byte (req_tlast),
      .push       (push),
      .idle       (front_idle)
   );

   jsu_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .stat  (qstat)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (qstat.empty),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_byte   (out_byte),
      .rsp_status (status),
      .rsp_length (decoded_length),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {decoded_length, out_byte};
   assign rsp_tuser = status;

   a_error_to_idle: assert property (@(posedge clock) disable iff (reset)
      (push.valid && push.group.status == ST_ERROR) |=> front_idle)
      else $error("decode FSM not idle after error");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qstat.count <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status != ST_DATA) |-> (rsp_tlast && out_byte == 8'd0))
      else $error("end or error item not single");

   a_data_no_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status != ST_CLOSE) |-> (decoded_length == 16'd0))
      else $error("length on non-end item");

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the JSON string unescaper. Quoted strings with
// plain bytes, simple escapes, \u escapes in mixed hex case, surrogate pairs
// and lone low surrogates go in, some of them cut short or corrupted. A
// software copy of the decoder predicts every response byte, end item and
// error item, and each accepted response is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
   import jsu_pkg::*;

   typedef enum logic [2:0] {
      DEC_IDLE, DEC_BODY, DEC_ESC, DEC_HEX, DEC_WANT_BS, DEC_WANT_U, DEC_HEX_LOW
   } dec_mode_type;

   typedef struct packed {
      logic [7:0]  ch;
      logic [1:0]  status;
      logic [15:0] count;
      logic        last;
   } rsp_item_type;

   class unescape_scoreboard_type;
      rsp_item_type decoded_q[$];
      dec_mode_type mode;
      logic [15:0]  acc;
      logic [9:0]   hi_part;
      int           digits;
      logic [15:0]  byte_count;
      int           failures;
      int           requests;
      int           data_seen;
      int           closes_seen;
      int           errors_seen;

      function new();
         clear();
         failures = 0;
         requests = 0;
         data_seen = 0;
         closes_seen = 0;
         errors_seen = 0;
      endfunction

      function void clear();
         mode = DEC_IDLE;
         acc = '0;
         hi_part = '0;
         digits = 0;
         byte_count = '0;
      endfunction

      function int nibble_of(logic [7:0] c);
         if (c >= "0" && c <= "9") return int'(c - "0");
         if (c >= "a" && c <= "f") return int'(c - "a") + 10;
         if (c >= "A" && c <= "F") return int'(c - "A") + 10;
         return -1;
      endfunction

      function int to_utf8(logic [20:0] cp, output logic [3:0][7:0] o);
         o = '0;
         if (cp < 21'h80) begin
            o[0] = cp[7:0];
            return 1;
         end
         if (cp < 21'h800) begin
            o[0] = 8'hC0 | 8'(cp >> 6);
            o[1] = 8'h80 | 8'(cp & 21'h3F);
            return 2;
         end
         if (cp < 21'h10000) begin
            o[0] = 8'hE0 | 8'(cp >> 12);
            o[1] = 8'h80 | 8'((cp >> 6) & 21'h3F);
            o[2] = 8'h80 | 8'(cp & 21'h3F);
            return 3;
         end
         o[0] = 8'hF0 | 8'((cp >> 18) & 21'h07);
         o[1] = 8'h80 | 8'((cp >> 12) & 21'h3F);
         o[2] = 8'h80 | 8'((cp >> 6) & 21'h3F);
         o[3] = 8'h80 | 8'(cp & 21'h3F);
         return 4;
      endfunction

      function void note_request(logic [7:0] c, logic fin);
         logic [3:0][7:0] ob;
         int              n;
         bit              err;
         bit              closed;
         int              d;
         logic [20:0]     cp;
         rsp_item_type    item;
         ob = '0;
         n = 0;
         err = 0;
         closed = 0;
         requests++;
         case (mode)
            DEC_IDLE: begin
               if (c == CH_QUOTE) begin
                  clear();
                  mode = DEC_BODY;
               end else err = 1;
            end
            DEC_BODY: begin
               if (c == CH_QUOTE) closed = 1;
               else if (c == CH_BSLASH) mode = DEC_ESC;
               else if (c < CH_SPACE) err = 1;
               else begin
                  ob[0] = c;
                  n = 1;
               end
            end
            DEC_ESC: begin
               mode = DEC_BODY;
               n = 1;
               case (c)
                  CH_QUOTE, CH_BSLASH, CH_SLASH: ob[0] = c;
                  CH_B: ob[0] = CTL_BS;
                  CH_F: ob[0] = CTL_FF;
                  CH_N: ob[0] = CTL_LF;
                  CH_R: ob[0] = CTL_CR;
                  CH_T: ob[0] = CTL_HT;
                  CH_U: begin
                     n = 0;
                     mode = DEC_HEX;
                     acc = '0;
                     digits = 0;
                  end
                  default: begin
                     n = 0;
                     err = 1;
                  end
               endcase
            end
            DEC_HEX, DEC_HEX_LOW: begin
               d = nibble_of(c);
               if (d < 0) err = 1;
               else begin
                  acc = {acc[11:0], 4'(d)};
                  if (digits < 3) digits++;
                  else begin
                     digits = 0;
                     cp = {5'd0, acc};
                     if (mode == DEC_HEX && acc >= 16'hD800 && acc <= 16'hDBFF) begin
                        hi_part = acc[9:0];
                        mode = DEC_WANT_BS;
                     end else if (mode == DEC_HEX_LOW &&
                                  (acc < 16'hDC00 || acc > 16'hDFFF)) begin
                        err = 1;
                     end else begin
                        if (mode == DEC_HEX_LOW) cp = 21'h10000 + {1'b0, hi_part, acc[9:0]};
                        n = to_utf8(cp, ob);
                        mode = DEC_BODY;
                     end
                  end
               end
            end
            DEC_WANT_BS: begin
               if (c == CH_BSLASH) mode = DEC_WANT_U;
               else err = 1;
            end
            DEC_WANT_U: begin
               if (c == CH_U) begin
                  mode = DEC_HEX_LOW;
                  acc = '0;
                  digits = 0;
               end else err = 1;
            end
            default: err = 1;
         endcase

         if (!err && !closed && fin) err = 1;

         if (err) begin
            clear();
            item = '{ch: 8'h00, status: ST_ERROR, count: 16'h0, last: 1'b1};
            decoded_q.push_back(item);
         end else if (closed) begin
            item = '{ch: 8'h00, status: ST_CLOSE, count: byte_count, last: 1'b1};
            decoded_q.push_back(item);
            clear();
         end else begin
            for (int k = 0; k < n; k++) begin
               if (byte_count != 16'hFFFF) byte_count++;
               item = '{ch: ob[k], status: ST_DATA, count: 16'h0, last: (k == n - 1)};
               decoded_q.push_back(item);
            end
         end
      endfunction

      function void check_response(logic [23:0] data, logic [1:0] user, logic last);
         rsp_item_type e;
         if (decoded_q.size() == 0) begin
            $error("unexpected response: tdata %h tuser %h tlast %b", data, user, last);
            failures++;
            return;
         end
         e = decoded_q.pop_front();
         case (e.status)
            ST_DATA: data_seen++;
            ST_CLOSE: closes_seen++;
            default: errors_seen++;
         endcase
         if (data[7:0] !== e.ch) begin
            $error("out_byte: expected %h, got %h", e.ch, data[7:0]);
            failures++;
         end
         if (user !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, user);
            failures++;
         end
         if (data[23:8] !== e.count) begin
            $error("decoded_length: expected %0d, got %0d", e.count, data[23:8]);
            failures++;
         end
         if (last !== e.last) begin
            $error("last: expected %b, got %b", e.last, last);
            failures++;
         end
      endfunction

      function int pending();
         return decoded_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   int          send_idle_pct = 10;
   int          recv_idle_pct = 72;
   int          items_sent = 0;
   logic [7:0]  src_q[$];
   unescape_scoreboard_type sb = new();

   json_string_unescape_top #(.LENGTH_BITS(16)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   initial begin
      #3000000;
      $display("status: fail");
      $finish;
   end

   task automatic push_byte(input logic [7:0] c, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(c, fin);
      items_sent++;
   endtask

   task automatic play_text(input bit fin_last);
      for (int i = 0; i < src_q.size(); i++) begin
         push_byte(src_q[i], fin_last && (i == src_q.size() - 1));
      end
      src_q.delete();
   endtask

   function automatic void add_hex16(logic [15:0] v);
      logic [3:0] nib;
      src_q.push_back(CH_BSLASH);
      src_q.push_back(CH_U);
      for (int i = 3; i >= 0; i--) begin
         nib = v[i*4 +: 4];
         if (nib < 10) src_q.push_back(8'("0") + 8'(nib));
         else if ($urandom_range(1)) src_q.push_back(8'("a") + 8'(nib) - 8'd10);
         else src_q.push_back(8'("A") + 8'(nib) - 8'd10);
      end
   endfunction

   function automatic void add_piece();
      logic [7:0]  c;
      logic [15:0] v;
      logic [7:0]  simple[8];
      simple = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            do c = 8'($urandom_range(8'hFF, 8'h20));
            while (c == CH_QUOTE || c == CH_BSLASH);
            src_q.push_back(c);
         end
         4: begin
            src_q.push_back(CH_BSLASH);
            src_q.push_back(simple[$urandom_range(7)]);
         end
         5: add_hex16(16'($urandom_range(16'h7F, 16'h0)));
         6: add_hex16(16'($urandom_range(16'h7FF, 16'h80)));
         7: begin
            v = 16'($urandom_range(16'hFFFF, 16'h800));
            if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h4000;
            add_hex16(v);
         end
         8: add_hex16(16'($urandom_range(16'hDFFF, 16'hDC00)));
         default: begin
            add_hex16(16'($urandom_range(16'hDBFF, 16'hD800)));
            add_hex16(16'($urandom_range(16'hDFFF, 16'hDC00)));
         end
      endcase
   endfunction

   task automatic random_phase(input int count);
      int stop_at;
      int cut;
      int roll;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 6) begin
            push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
         end else begin
            src_q.push_back(CH_QUOTE);
            repeat ($urandom_range(4)) add_piece();
            src_q.push_back(CH_QUOTE);
            if (roll < 40) begin
               cut = $urandom_range(src_q.size() - 1);
               if ($urandom_range(1)) src_q[cut] = 8'($urandom_range(255));
               while (src_q.size() > cut + 1) void'(src_q.pop_back());
               play_text(1'b1);
            end else begin
               play_text($urandom_range(3) == 0);
            end
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_byte(8'h00, 1'b0);
      push_byte(CH_QUOTE, 1'b0);
      push_byte(CH_QUOTE, 1'b1);
      push_byte(CH_QUOTE, 1'b1);
      src_q = '{CH_QUOTE, 8'hFF, CH_SPACE, CH_BSLASH, CH_T, CH_BSLASH, CH_U,
                "0", "0", "0", "0", CH_BSLASH, CH_U, "D", "f", "F", "f", CH_QUOTE};
      play_text(1'b0);
      push_byte(CH_QUOTE, 1'b0);
      push_byte(8'h1F, 1'b0);

      random_phase(80);
      send_idle_pct = 72;
      recv_idle_pct = 10;
      random_phase(80);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(80);
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("covered %0d requests, %0d decoded bytes, %0d closed strings, %0d errors",
               sb.requests, sb.data_seen, sb.closes_seen, sb.errors_seen);
      $display("including escapes, surrogate pairs, lone low surrogates and cut input");
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* json_string_unescape_top.f */
sv/jsu_pkg.sv
sv/jsu_front.sv
sv/jsu_queue.sv
sv/jsu_back.sv
sv/json_string_unescape_top.sv
test/tb.sv
